// ===== rtl/cshash_pkg.sv =====
// Shared types, constants and the CRC32C byte step for the hash unit.
// No dependencies; used by every module of the block.
package cshash_pkg;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned CRC_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned COUNT_SHIFT = 24;

    localparam logic [CRC_W-1:0] CRC_POLY_REV = 32'h82F6_3B78;
    localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

    // One finished message waiting for the finalizer: the pre-mix key.
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
    } req_t;

    // Reflected CRC32C update by one byte, one polynomial step per bit.
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY_REV : '0);
        end
        return c;
    endfunction

endpackage

// ===== rtl/cshash_front.sv =====
// Front end: accepts message bytes, runs the CRC and byte count, and
// emits one pre-mix key per message. Depends on cshash_pkg.
module cshash_front #(
    parameter int unsigned LENGTH_BITS = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [cshash_pkg::BYTE_W-1:0] data_byte,
    input  logic                          has_byte,
    input  logic                          last,
    input  logic [cshash_pkg::KEY_W-1:0]  seed,
    output cshash_pkg::req_t              push
);

    logic [cshash_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic [LENGTH_BITS-1:0]       count_reg, count_next;
    logic                         mid_reg, mid_next;

    logic [cshash_pkg::CRC_W-1:0] crc_start, crc_done;
    logic [LENGTH_BITS-1:0]       count_start;
    logic [cshash_pkg::KEY_W-1:0] count_wide;
    logic                         active;

    assign active = accept && (has_byte || last);

    always_comb begin
        crc_start   = mid_reg ? crc_reg : ~seed[cshash_pkg::CRC_W-1:0];
        count_start = mid_reg ? count_reg : '0;
        crc_next    = crc_reg;
        count_next  = count_reg;
        mid_next    = mid_reg;
        if (active) begin
            crc_next   = has_byte ? cshash_pkg::crc_byte(crc_start, data_byte) : crc_start;
            count_next = has_byte ? count_start + LENGTH_BITS'(1) : count_start;
            mid_next   = !last;
        end
    end

    // Close the message: complement, double, mix in seed and shifted count.
    always_comb begin
        crc_done   = ~crc_next;
        count_wide = {{(cshash_pkg::KEY_W-LENGTH_BITS){1'b0}}, count_next}
                     << cshash_pkg::COUNT_SHIFT;
        push.vld   = active && last;
        push.key   = {crc_done, crc_done} ^ seed ^ count_wide;
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (!aresetn) begin
            count_reg <= '0;
            mid_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            mid_reg   <= mid_next;
        end
    end

endmodule

// ===== rtl/cshash_fifo.sv =====
// Two-entry queue of pre-mix keys between the front end and the finalizer.
// Depends on cshash_pkg.
module cshash_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  cshash_pkg::req_t push,
    input  logic             pop,
    output cshash_pkg::req_t head,
    output logic             full
);

    logic [cshash_pkg::KEY_W-1:0] slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign do_push  = push.vld && !full;
    assign do_pop   = pop && head.vld;
    assign full     = (fill_reg == 2'd2);
    assign head.vld = (fill_reg != 2'd0);
    assign head.key = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.key;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/cshash_mix.sv =====
// Back end: SplitMix64-style finalizer with one shared 32x32 multiplier,
// three partial products per 64-bit multiply. Depends on cshash_pkg.
module cshash_mix (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cshash_pkg::req_t             head,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cshash_pkg::KEY_W-1:0] m_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P0   = 3'd1;
    localparam logic [2:0] ST_P1   = 3'd2;
    localparam logic [2:0] ST_P2   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        pass_reg, pass_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic        out_vld_reg, out_vld_next;
    logic [63:0] out_reg, out_next;

    logic [63:0] kmul;
    logic [31:0] mul_a, mul_b, hi_sum;
    logic [63:0] prod, y;
    logic        out_free;

    assign out_free = !out_vld_reg || m_tready;
    assign kmul     = pass_reg ? cshash_pkg::MIX_MUL_B : cshash_pkg::MIX_MUL_A;
    assign mul_a    = (state_reg == ST_P2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b    = (state_reg == ST_P1) ? kmul[63:32] : kmul[31:0];
    assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
    assign hi_sum   = acc_reg[63:32] + prod[31:0];
    assign y        = {hi_sum, acc_reg[31:0]};

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        x_next       = x_reg;
        acc_next     = acc_reg;
        out_vld_next = out_vld_reg && !m_tready;
        out_next     = out_reg;
        pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (head.vld) begin
                    pop        = 1'b1;
                    x_next     = head.key ^ (head.key >> 30);
                    pass_next  = 1'b0;
                    state_next = ST_P0;
                end
            end
            ST_P0: begin
                acc_next   = prod;
                state_next = ST_P1;
            end
            ST_P1: begin
                acc_next   = y;
                state_next = ST_P2;
            end
            ST_P2: begin
                // Second pass leaves the raw product; xor-shift 31 at the output.
                if (!pass_reg) begin
                    x_next     = y ^ (y >> 27);
                    pass_next  = 1'b1;
                    state_next = ST_P0;
                end else begin
                    x_next     = y;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_next     = x_reg ^ (x_reg >> 31);
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pass_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/crc32c_splitmix_hash_unit.sv =====
// Top level of the CRC32C + SplitMix64 message hash unit.
// Depends on cshash_pkg, cshash_front, cshash_fifo and cshash_mix.
//
// Usage:
//   Send a message as a stream of requests on the s_ channel, one byte per
//   request. s_tuser[0] flags that s_tdata carries a byte; s_tlast closes
//   the message. A request with no byte and no last is ignored; one with no
//   byte but last on an idle stream hashes the empty message.
//   Each closed message yields one 64-bit hash on the m_ channel.
//   The seed is written through cfg_we/cfg_wdata; the user must do so only
//   while the unit is idle, as the unit itself does not enforce this.
// Throughput: one byte per cycle while s_tready is high; the CRC step is one
//   byte per cycle in the front end. The finalizer takes one message at a time
//   (six 32x32 partial products on one shared multiplier plus load and output),
//   so messages shorter than about 8 bytes are limited by the finalizer.
// Path: queue, then finalizer load, P0, P1, P2 for each pass, output, m_tvalid.
// Reset: clears the seed to zero, the byte count, the open-message flag,
//   the queue and the output. No clearing pass is needed.
// Stall: a held m_ result keeps the finalizer waiting; the two-entry queue
//   then fills and s_tready drops until space frees up.
module crc32c_splitmix_hash_unit #(
    parameter int unsigned LENGTH_BITS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // last
    // Hash results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] hash_value
    // Seed register
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata  // [63:0] hash_seed
);

    logic [cshash_pkg::KEY_W-1:0] seed_reg, seed_next;
    cshash_pkg::req_t             push, head;
    logic                         fifo_full;
    logic                         pop;
    logic                         s_accept;

    // Hold the seed until the next write.
    assign seed_next = cfg_we ? cfg_wdata : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else begin
            seed_reg <= seed_next;
        end
    end

    // Stall input whenever the queue has no room for a closing request.
    assign s_tready = !fifo_full;
    assign s_accept = s_tvalid && s_tready;

    cshash_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .data_byte(s_tdata),
        .has_byte (s_tuser[0]),
        .last     (s_tlast),
        .seed     (seed_reg),
        .push     (push)
    );

    cshash_fifo u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .full   (fifo_full)
    );

    cshash_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // A closing request is never pushed into a full queue.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld |-> !fifo_full)
        else $error("closing request pushed into full queue");

    // The finalizer only takes a key that is present.
    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.vld)
        else $error("finalizer popped an empty queue");

    // Reset leaves no result pending.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
